FILE: hdl/pidl_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Shared constants, command and status codes, and the control structs that
// pass between the list controller and the list datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

   // Fixed field widths of the command and result channels.
   localparam int OPCODE_W    = 3;
   localparam int POS_W       = 7;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;

   // Command opcodes.
   localparam logic [OPCODE_W-1:0] OP_READOUT  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INS_HEAD = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INS_TAIL = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_INS_POS  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DEL_HEAD = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_DEL_TAIL = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_DEL_POS  = 3'd6;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch a new command and decode it
      logic apply;      // update the list and issue the single result
      logic read_step;  // issue one readout beat and rotate the list
   } pidl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic read_list;  // latched command is a readout of a non-empty list
      logic read_last;  // the current readout beat is the final one
   } pidl_stat_type;

endpackage

`default_nettype wire

FILE: hdl/pidl_ctrl.sv
// ----------------------------------------------------------------------------
// Positional list controller
// Sequences each command through capture, execute and, for a readout of a
// non-empty list, one readout beat per stored entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_ctrl
   import pidl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire pidl_stat_type stat,
   output pidl_cmd_type       cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.apply     = 1'b0;
      cmd.read_step = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.read_list) begin
               state_in = S_READ;
            end else begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_READ: begin
            cmd.read_step = 1'b1;
            if (stat.read_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

FILE: hdl/pidl_dpath.sv
// ----------------------------------------------------------------------------
// Positional list datapath
// A row of register cells holding the packed list, the command decode and
// range checks, the removed-value select, and the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_dpath
   import pidl_pkg::*;
#(
   parameter int CAPACITY = 64
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pidl_cmd_type             cmd,
   output pidl_stat_type                 stat,
   input  wire logic [OPCODE_W-1:0]      req_opcode,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]      rsp_data,
   output logic [COUNT_OUT_W-1:0]        rsp_count_after,
   output logic                          rsp_last
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int ZW = ((CW > POS_W) ? CW : POS_W) + 1;

   // List storage and count.
   logic [DATA_W-1:0] cell_ff [CAPACITY];
   logic [DATA_W-1:0] cell_in [CAPACITY];
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [CW-1:0]     count_m1;

   // Latched command.
   logic [STATUS_W-1:0] st_ff;
   logic [CW-1:0]       idx_ff;
   logic [DATA_W-1:0]   val_ff;
   logic                ins_ff;
   logic                del_ff;
   logic                rdl_ff;
   logic [CW-1:0]       rd_ff;
   logic [DATA_W-1:0]   del_data_ff;

   // Decode results.
   logic [STATUS_W-1:0] st_c;
   logic [ZW-1:0]       idx_z;
   logic [CW-1:0]       idx_c;
   logic                ins_c;
   logic                del_c;
   logic                rdl_c;
   logic [ZW-1:0]       pos_z;
   logic [ZW-1:0]       cnt_z;
   logic                full;
   logic                empty;

   logic [DATA_W-1:0]   del_data;
   logic                rd_last;

   // Result registers.
   logic                   strobe_ff;
   logic                   strobe_in;
   logic [STATUS_W-1:0]    status_ff;
   logic [STATUS_W-1:0]    status_in;
   logic [DATA_W-1:0]      data_ff;
   logic [DATA_W-1:0]      data_in;
   logic [COUNT_OUT_W-1:0] cnt_out_ff;
   logic [COUNT_OUT_W-1:0] cnt_out_in;
   logic                   last_ff;
   logic                   last_in;

   assign pos_z    = ZW'(req_position);
   assign cnt_z    = ZW'(count_ff);
   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign count_m1 = count_ff - CW'(1);
   assign idx_c    = idx_z[CW-1:0];

   // Command decode and range checks; full and empty are checked first.
   always_comb begin
      st_c  = ST_OK;
      idx_z = '0;
      ins_c = 1'b0;
      del_c = 1'b0;
      rdl_c = 1'b0;
      unique case (req_opcode)
         OP_READOUT: begin
            if (empty) begin
               st_c = ST_EMPTY;
            end else begin
               rdl_c = 1'b1;
            end
         end
         OP_INS_HEAD: begin
            if (full) begin
               st_c = ST_FULL;
            end else begin
               ins_c = 1'b1;
            end
         end
         OP_INS_TAIL: begin
            if (full) begin
               st_c = ST_FULL;
            end else begin
               ins_c = 1'b1;
               idx_z = cnt_z;
            end
         end
         OP_INS_POS: begin
            if (full) begin
               st_c = ST_FULL;
            end else if ((pos_z == '0) || (pos_z > (cnt_z + ZW'(1)))) begin
               st_c = ST_BADPOS;
            end else begin
               ins_c = 1'b1;
               idx_z = pos_z - ZW'(1);
            end
         end
         OP_DEL_HEAD: begin
            if (empty) begin
               st_c = ST_EMPTY;
            end else begin
               del_c = 1'b1;
            end
         end
         OP_DEL_TAIL: begin
            if (empty) begin
               st_c = ST_EMPTY;
            end else begin
               del_c = 1'b1;
               idx_z = cnt_z - ZW'(1);
            end
         end
         OP_DEL_POS: begin
            if (empty) begin
               st_c = ST_EMPTY;
            end else if ((pos_z == '0) || (pos_z > cnt_z)) begin
               st_c = ST_BADPOS;
            end else begin
               del_c = 1'b1;
               idx_z = pos_z - ZW'(1);
            end
         end
         default: begin
            st_c = ST_BADPOS;
         end
      endcase
   end

   // The removed value is the cell at the target index.
   always_comb begin
      del_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CW'(i) == idx_c) begin
            del_data = cell_ff[i];
         end
      end
   end

   // Command latch.
   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff <= 1'b0;
         del_ff <= 1'b0;
         rdl_ff <= 1'b0;
      end else if (cmd.capture) begin
         ins_ff <= ins_c;
         del_ff <= del_c;
         rdl_ff <= rdl_c;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         st_ff       <= st_c;
         idx_ff      <= idx_c;
         val_ff      <= req_value;
         del_data_ff <= del_data;
      end
   end

   // Each cell updates from its neighbors: shift up on insert, shift down on
   // delete, and rotate the occupied part by one on each readout beat.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] up_val;
      logic [DATA_W-1:0] dn_val;

      if (i == 0) begin : g_first
         assign up_val = cell_ff[i];
      end else begin : g_up
         assign up_val = cell_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_final
         assign dn_val = cell_ff[i];
      end else begin : g_dn
         assign dn_val = cell_ff[i+1];
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (cmd.apply && ins_ff) begin
            if (CW'(i) == idx_ff) begin
               cell_in[i] = val_ff;
            end else if (CW'(i) > idx_ff) begin
               cell_in[i] = up_val;
            end
         end else if (cmd.apply && del_ff) begin
            if (CW'(i) >= idx_ff) begin
               cell_in[i] = dn_val;
            end
         end else if (cmd.read_step) begin
            if (CW'(i) < count_m1) begin
               cell_in[i] = dn_val;
            end else if (CW'(i) == count_m1) begin
               cell_in[i] = cell_ff[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (cmd.apply && ins_ff) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.apply && del_ff) begin
         count_in = count_m1;
      end
   end

   // Entry count register and readout beat counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.capture) begin
            rd_ff <= '0;
         end else if (cmd.read_step) begin
            rd_ff <= rd_ff + CW'(1);
         end
      end
   end

   assign rd_last = (rd_ff == count_m1);

   // Result register.
   always_comb begin
      strobe_in  = cmd.apply | cmd.read_step;
      status_in  = status_ff;
      data_in    = data_ff;
      cnt_out_in = cnt_out_ff;
      last_in    = last_ff;
      if (cmd.apply) begin
         status_in  = st_ff;
         data_in    = del_ff ? del_data_ff : '0;
         cnt_out_in = COUNT_OUT_W'(count_in);
         last_in    = 1'b1;
      end else if (cmd.read_step) begin
         status_in  = ST_OK;
         data_in    = cell_ff[0];
         cnt_out_in = COUNT_OUT_W'(count_ff);
         last_in    = rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      data_ff    <= data_in;
      cnt_out_ff <= cnt_out_in;
      last_ff    <= last_in;
   end

   assign stat.read_list  = rdl_ff;
   assign stat.read_last  = rd_last;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_data        = signed'(data_ff);
   assign rsp_count_after = cnt_out_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

FILE: hdl/positional_insert_delete_list_unit.sv
// ----------------------------------------------------------------------------
// Positional insert/delete list unit
// Packed list of signed 32-bit values with insert and delete at the head, the
// tail or a 1-based position, and readout of the whole list.
// ----------------------------------------------------------------------------
// Usage:
//   A command (req_opcode, req_position, req_value) is taken at a rising edge
//   where start is high and busy is low. Results appear on the rsp_ ports for
//   exactly one cycle each, marked by rsp_strobe; the receiver cannot stall.
//   Insert and delete commands give one result beat, with rsp_last high, after
//   the execute state; busy is low again in the cycle of that beat, so a new
//   command can be taken while the beat is presented.
//   A readout of a list holding N entries streams N beats, one per cycle,
//   head first, after the execute state; busy is low again on the final
//   beat. The list is a row of register cells that rotates by one per
//   beat, which sets the one-entry-per-cycle rate. A readout of an empty
//   list gives one beat with status empty.
//   Refused commands leave the list unchanged and report full, empty or
//   invalid position. rsp_count_after is the entry count modulo 128.
//   Reset empties the list; no clearing pass is needed, and the unit is
//   ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list_unit
   import pidl_pkg::*;
#(
   parameter int CAPACITY = 64
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [OPCODE_W-1:0]      req_opcode,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]      rsp_data,
   output logic [COUNT_OUT_W-1:0]        rsp_count_after,
   output logic                          rsp_last
);

   pidl_cmd_type  cmd;
   pidl_stat_type stat;

   // Command sequencer.
   pidl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // List storage and result path.
   pidl_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .rsp_count_after (rsp_count_after),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   // An accepted command keeps the unit busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting a command");

   // The final beat of a command is issued once the unit is free again.
   a_last_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("busy still high on the final beat");

   // A beat that is not final only occurs inside a readout.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("non-final beat while idle");

   // The reported count never exceeds the capacity, when the capacity is below 128.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((CAPACITY > 127) || (rsp_count_after <= COUNT_OUT_W'(CAPACITY))))
      else $error("reported count above capacity");
`endif

endmodule

`default_nettype wire

FILE: tb/positional_insert_delete_list_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional insert/delete list unit testbench
// Drives insert, delete and readout commands into the list unit and checks
// every result beat against a shadow copy of the list. A directed opening
// covers the empty-list and position edge cases and the unused opcode. Random
// traffic then fills the list to capacity and drains it again, with sender gaps
// that vary by phase.
// ----------------------------------------------------------------------------

// One result beat as the unit should present it.
typedef struct {
   logic [pidl_pkg::STATUS_W-1:0]      status;
   logic signed [pidl_pkg::DATA_W-1:0] data;
   logic [pidl_pkg::COUNT_OUT_W-1:0]   count_after;
   logic                               last;
} list_beat_type;

// Shadow list and queue of result beats still owed by the unit.
class list_scoreboard;
   logic signed [pidl_pkg::DATA_W-1:0] cells[];
   int            depth;
   int            count;
   int            errors;
   list_beat_type owed_beats[$];

   function new(int depth_i);
      depth  = depth_i;
      cells  = new[depth_i];
      count  = 0;
      errors = 0;
   endfunction

   // Queue one beat, stamped with the entry count after the command.
   function void owe_beat(logic [pidl_pkg::STATUS_W-1:0] st,
                          logic signed [pidl_pkg::DATA_W-1:0] d, logic lst);
      list_beat_type beat;
      beat.status      = st;
      beat.data        = d;
      beat.count_after = count[pidl_pkg::COUNT_OUT_W-1:0];
      beat.last        = lst;
      owed_beats.push_back(beat);
   endfunction

   // Insert at a 0-based index, shifting later entries up.
   function logic [pidl_pkg::STATUS_W-1:0] insert_at(int idx,
                                                      logic signed [31:0] v);
      if (count >= depth) return pidl_pkg::ST_FULL;
      if (idx > count) return pidl_pkg::ST_BADPOS;
      for (int i = count; i > idx; i--) cells[i] = cells[i-1];
      cells[idx] = v;
      count++;
      return pidl_pkg::ST_OK;
   endfunction

   // Delete at a 0-based index, shifting later entries down.
   function logic [pidl_pkg::STATUS_W-1:0] delete_at(int idx,
                                                      output logic signed [31:0] d);
      d = '0;
      if (count == 0) return pidl_pkg::ST_EMPTY;
      if (idx >= count) return pidl_pkg::ST_BADPOS;
      d = cells[idx];
      for (int i = idx; i + 1 < count; i++) cells[i] = cells[i+1];
      count--;
      return pidl_pkg::ST_OK;
   endfunction

   // Update the shadow list for an accepted command and queue its beats.
   function void note_command(logic [pidl_pkg::OPCODE_W-1:0] op,
                              logic [pidl_pkg::POS_W-1:0] pos,
                              logic signed [pidl_pkg::DATA_W-1:0] val);
      logic [pidl_pkg::STATUS_W-1:0]      st;
      logic signed [pidl_pkg::DATA_W-1:0] d;
      int                                 pidx;
      d    = '0;
      pidx = int'(pos) - 1;
      case (op)
         pidl_pkg::OP_READOUT: begin
            if (count == 0) begin
               owe_beat(pidl_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < count; i++)
                  owe_beat(pidl_pkg::ST_OK, cells[i], (i + 1 == count));
            end
            return;
         end
         pidl_pkg::OP_INS_HEAD: st = insert_at(0, val);
         pidl_pkg::OP_INS_TAIL: st = insert_at(count, val);
         pidl_pkg::OP_INS_POS: begin
            if (count >= depth) st = pidl_pkg::ST_FULL;
            else if (pos == 0) st = pidl_pkg::ST_BADPOS;
            else st = insert_at(pidx, val);
         end
         pidl_pkg::OP_DEL_HEAD: st = delete_at(0, d);
         pidl_pkg::OP_DEL_TAIL: st = delete_at((count == 0) ? 0 : count - 1, d);
         pidl_pkg::OP_DEL_POS: begin
            if (count == 0) st = pidl_pkg::ST_EMPTY;
            else if (pos == 0) st = pidl_pkg::ST_BADPOS;
            else st = delete_at(pidx, d);
         end
         default: st = pidl_pkg::ST_BADPOS;
      endcase
      owe_beat(st, d, 1'b1);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endfunction

   // Compare an accepted result beat with the oldest owed beat.
   function void check_beat(logic [pidl_pkg::STATUS_W-1:0] st,
                            logic signed [pidl_pkg::DATA_W-1:0] d,
                            logic [pidl_pkg::COUNT_OUT_W-1:0] cnt, logic lst);
      list_beat_type want;
      if (owed_beats.size() == 0) begin
         errors++;
         $display("%0t: unexpected result beat, expected none actual status %0d data %h",
                  $time, st, d);
         return;
      end
      want = owed_beats.pop_front();
      compare_field("status", 32'(want.status), 32'(st));
      compare_field("data", want.data, d);
      compare_field("count_after", 32'(want.count_after), 32'(cnt));
      compare_field("last", 32'(want.last), 32'(lst));
   endfunction
endclass

module positional_insert_delete_list_unit_tb;
   import pidl_pkg::*;

   localparam int LIST_DEPTH   = 64;
   localparam int RANDOM_ITEMS = 170;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;

   // The unit leaves opcode 7 unused; it must be refused.
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          start        = 1'b0;
   logic [OPCODE_W-1:0]           req_opcode   = '0;
   logic [POS_W-1:0]              req_position = '0;
   logic signed [DATA_W-1:0]      req_value    = '0;
   logic                          busy;
   logic                          rsp_strobe;
   logic [STATUS_W-1:0]           rsp_status;
   logic signed [DATA_W-1:0]      rsp_data;
   logic [COUNT_OUT_W-1:0]        rsp_count_after;
   logic                          rsp_last;

   list_scoreboard shadow = new(LIST_DEPTH);
   int             stall_run = 0;

   positional_insert_delete_list_unit #(
      .CAPACITY(LIST_DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .rsp_count_after (rsp_count_after),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Present one command and hold it until the unit takes the beat.
   task automatic send_command(input logic [OPCODE_W-1:0] op,
                               input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
      start        <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow.note_command(op, pos, val);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending until every owed beat has come back.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (shadow.owed_beats.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly valid positions, with some noise over the whole field.
   function automatic logic [POS_W-1:0] pick_position(input int hi);
      if ($urandom_range(9) == 0 || hi < 1) return POS_W'($urandom_range(127));
      return POS_W'($urandom_range(hi, 1));
   endfunction

   // One random command, biased toward growing or shrinking the list.
   task automatic random_command(input bit filling);
      logic [OPCODE_W-1:0] op;
      int                  r;
      int                  n;
      r = $urandom_range(99);
      n = shadow.count;
      if (r < 6) op = OP_READOUT;
      else if (r < 8) op = OP_UNUSED;
      else if (filling) begin
         if (r < 36) op = OP_INS_HEAD;
         else if (r < 62) op = OP_INS_TAIL;
         else if (r < 92) op = OP_INS_POS;
         else if (r < 95) op = OP_DEL_HEAD;
         else if (r < 97) op = OP_DEL_TAIL;
         else op = OP_DEL_POS;
      end else begin
         if (r < 11) op = OP_INS_HEAD;
         else if (r < 14) op = OP_INS_POS;
         else if (r < 40) op = OP_DEL_HEAD;
         else if (r < 66) op = OP_DEL_TAIL;
         else op = OP_DEL_POS;
      end
      send_command(op, pick_position((op == OP_INS_POS) ? n + 1 : n), pick_value());
   endtask

   // Check every result beat the unit presents.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         shadow.check_beat(rsp_status, rsp_data, rsp_count_after, rsp_last);
   end

   // Watchdog on cycles in which no beat moves on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_run = 0;
      end else begin
         stall_run++;
         if (stall_run >= IDLE_LIMIT) begin
            $display("positional_insert_delete_list_unit regression: fail");
            $finish;
         end
      end
   end

   initial begin
      bit filling;
      int idle_pct;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: refusals on an empty list.
      send_command(OP_READOUT, 7'd0, 32'sd0);
      send_command(OP_DEL_HEAD, 7'd0, 32'sd0);
      send_command(OP_DEL_TAIL, 7'd0, 32'sd0);
      send_command(OP_DEL_POS, 7'd1, 32'sd0);
      send_command(OP_INS_POS, 7'd0, 32'sd5);
      send_command(OP_INS_POS, 7'd2, 32'sd5);
      // Directed: inserts with extreme values at every place.
      send_command(OP_INS_POS, 7'd1, 32'sh8000_0000);
      send_command(OP_INS_HEAD, 7'd0, 32'sh7fff_ffff);
      send_command(OP_INS_TAIL, 7'd127, -32'sd1);
      send_command(OP_INS_POS, 7'd4, 32'sd0);
      send_command(OP_INS_POS, 7'd2, 32'sh1234_5678);
      send_command(OP_READOUT, 7'd0, 32'sd0);
      // Directed: positions just outside the range, and the unused opcode.
      send_command(OP_DEL_POS, 7'd0, 32'sd0);
      send_command(OP_DEL_POS, 7'd6, 32'sd0);
      send_command(OP_DEL_POS, 7'd127, 32'sd0);
      send_command(OP_INS_POS, 7'd127, 32'sd9);
      send_command(OP_UNUSED, 7'd1, 32'sd9);
      // Directed: deletes back down to empty.
      send_command(OP_DEL_POS, 7'd3, 32'sd0);
      send_command(OP_DEL_HEAD, 7'd0, 32'sd0);
      send_command(OP_DEL_TAIL, 7'd0, 32'sd0);
      send_command(OP_READOUT, 7'd0, 32'sd0);
      send_command(OP_DEL_POS, 7'd2, 32'sd0);
      send_command(OP_DEL_HEAD, 7'd0, 32'sd0);
      send_command(OP_READOUT, 7'd0, 32'sd0);
      wait_drained();

      // Random: fill to capacity, linger at full, drain, linger at empty.
      filling = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) wait_drained();
         if (n < RANDOM_ITEMS / 3) idle_pct = 20;
         else if (n < 2 * RANDOM_ITEMS / 3) idle_pct = 62;
         else idle_pct = 0;
         if ($urandom_range(99) < idle_pct) hold_off($urandom_range(4, 1));
         if (filling && shadow.count >= LIST_DEPTH && $urandom_range(3) == 0)
            filling = 1'b0;
         else if (!filling && shadow.count == 0 && $urandom_range(3) == 0)
            filling = 1'b1;
         random_command(filling);
      end

      // Let the last beats arrive, then a few quiet cycles for strays.
      start <= 1'b0;
      while (shadow.owed_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (shadow.errors == 0 && shadow.owed_beats.size() == 0) begin
         $display("positional_insert_delete_list_unit regression: pass");
      end else begin
         $display("positional_insert_delete_list_unit regression: fail");
      end
      $finish;
   end

endmodule

FILE: positional_insert_delete_list_unit.f
hdl/pidl_pkg.sv
hdl/pidl_ctrl.sv
hdl/pidl_dpath.sv
hdl/positional_insert_delete_list_unit.sv
tb/positional_insert_delete_list_unit_tb.sv
